FILE: rtl/mm64_pkg.sv
// Shared constants, handshake types and helpers for the MurmurHash64A stream hasher.
package mm64_pkg;

  localparam logic [63:0] MixMult  = 64'hc6a4_a793_5bd1_e995;
  localparam int unsigned MixShift = 47;

  // Request into the shared constant multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  // Status back from the shared constant multiplier.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  // Keep the low n bytes of a tail word, n in 1..7.
  function automatic logic [63:0] tail_mask(input logic [2:0] nbytes);
    logic [63:0] mask;
    case (nbytes)
      3'd1:    mask = 64'h0000_0000_0000_00ff;
      3'd2:    mask = 64'h0000_0000_0000_ffff;
      3'd3:    mask = 64'h0000_0000_00ff_ffff;
      3'd4:    mask = 64'h0000_0000_ffff_ffff;
      3'd5:    mask = 64'h0000_00ff_ffff_ffff;
      3'd6:    mask = 64'h0000_ffff_ffff_ffff;
      3'd7:    mask = 64'h00ff_ffff_ffff_ffff;
      default: mask = 64'h0;
    endcase
    return mask;
  endfunction

endpackage

FILE: rtl/mm64_mul.sv
// Iterative 64-bit multiplier by the mix constant, one 32x32 partial product per cycle.
module mm64_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mm64_pkg::mul_req_t req_i,
  output mm64_pkg::mul_rsp_t rsp_o
);

  localparam logic [1:0] LastStep = 2'd2;

  logic [63:0] a_q, a_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  logic [31:0] x_sel, y_sel;
  logic [63:0] pp;
  logic [63:0] addend;

  // Low 64 bits only: al*ml + ((ah*ml + al*mh) << 32).
  always_comb begin
    case (step_q)
      2'd0:    begin x_sel = a_q[31:0];  y_sel = mm64_pkg::MixMult[31:0];  end
      2'd1:    begin x_sel = a_q[63:32]; y_sel = mm64_pkg::MixMult[31:0];  end
      default: begin x_sel = a_q[31:0];  y_sel = mm64_pkg::MixMult[63:32]; end
    endcase
    pp     = 64'(x_sel) * 64'(y_sel);
    addend = (step_q == 2'd0) ? pp : {pp[31:0], 32'h0};
  end

  always_comb begin
    a_d    = a_q;
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.operand;
      acc_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d  = acc_q + addend;
      step_d = step_q + 2'd1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      acc_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      a_q    <= a_d;
      acc_q  <= acc_d;
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

FILE: rtl/murmur64a_stream_hash_top.sv
// Top level of the MurmurHash64A stream hasher: sequencer, seed register, result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | data_word_i, valid_bytes_i, last_word_i,
//          |           |                         | message_length_i
//  out     | source    | out_valid_o/out_stall_i | hash_value_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_data_i (hash_seed)
//
// Every multiply by the mix constant runs on one shared unit as three 32x32 partial
// products. A beat takes a dispatch step plus one multiply per mix: one on the first
// word of a message (seeding), three for a full word, one for a tail, and on the last
// word one for the finalizer and a step to load the result. The input stalls until
// the beat is done, so a new word is taken only once the sequencer is back in idle.
// Reset clears the seed, the message flag and the result valid. The next beat is taken
// while a result waits; a finished hash holds in the sequencer while that result is stalled.
module murmur64a_stream_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  input  logic [31:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StDisp,
    StSeed,
    StKey1,
    StKey2,
    StHmul,
    StFin,
    StOut
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] seed_q, seed_d;
  logic [63:0] h_q, h_d;
  logic        inside_q, inside_d;
  logic [63:0] word_q, word_d;
  logic [3:0]  nbytes_q, nbytes_d;
  logic        last_q, last_d;
  logic [31:0] len_q, len_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q, hash_d;

  mm64_pkg::mul_req_t mul_req;
  mm64_pkg::mul_rsp_t mul_rsp;

  logic        in_fire;
  logic        pre_go, post_go;
  logic [63:0] pre_h, post_h;
  logic [63:0] prod;

  mm64_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign prod        = mul_rsp.product;
  assign in_stall_o  = (state_q != StIdle);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    h_d         = h_q;
    inside_d    = inside_q;
    word_d      = word_q;
    nbytes_d    = nbytes_q;
    last_d      = last_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && out_stall_i;
    hash_d      = hash_q;
    mul_req     = '0;
    pre_go      = 1'b0;
    pre_h       = h_q;
    post_go     = 1'b0;
    post_h      = h_q;

    // Seed writes must come only while idle; the block does not enforce this and takes them.
    if (cfg_valid_i) begin
      seed_d = cfg_data_i;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          word_d   = data_word_i;
          nbytes_d = valid_bytes_i;
          last_d   = last_word_i;
          len_d    = message_length_i;
          state_d  = StDisp;
        end
      end
      StDisp: begin
        if (!inside_q) begin
          // First word: seed the hash with length * M.
          mul_req.start   = 1'b1;
          mul_req.operand = {32'h0, len_q};
          inside_d        = 1'b1;
          state_d         = StSeed;
        end else begin
          pre_go = 1'b1;
          pre_h  = h_q;
        end
      end
      StSeed: begin
        if (mul_rsp.done) begin
          pre_go = 1'b1;
          pre_h  = seed_q ^ prod;
        end
      end
      StKey1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = prod ^ (prod >> mm64_pkg::MixShift);
          state_d         = StKey2;
        end
      end
      StKey2: begin
        if (mul_rsp.done) begin
          h_d             = h_q ^ prod;
          mul_req.start   = 1'b1;
          mul_req.operand = h_q ^ prod;
          state_d         = StHmul;
        end
      end
      StHmul: begin
        if (mul_rsp.done) begin
          post_go = 1'b1;
          post_h  = prod;
        end
      end
      StFin: begin
        if (mul_rsp.done) begin
          h_d     = prod ^ (prod >> mm64_pkg::MixShift);
          state_d = StOut;
        end
      end
      StOut: begin
        // Hold the finished hash until the result register frees up.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          hash_d      = h_q;
          inside_d    = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Mix the word in: full key, masked tail, or nothing for zero bytes.
    if (pre_go) begin
      h_d = pre_h;
      if (nbytes_q[3]) begin
        mul_req.start   = 1'b1;
        mul_req.operand = word_q;
        state_d         = StKey1;
      end else if (nbytes_q[2:0] != 3'd0) begin
        h_d             = pre_h ^ (word_q & mm64_pkg::tail_mask(nbytes_q[2:0]));
        mul_req.start   = 1'b1;
        mul_req.operand = pre_h ^ (word_q & mm64_pkg::tail_mask(nbytes_q[2:0]));
        state_d         = StHmul;
      end else begin
        post_go = 1'b1;
        post_h  = pre_h;
      end
    end

    // After the word: finalize on the last beat, else go back for the next.
    if (post_go) begin
      h_d = post_h;
      if (last_q) begin
        mul_req.start   = 1'b1;
        mul_req.operand = post_h ^ (post_h >> mm64_pkg::MixShift);
        state_d         = StFin;
      end else begin
        state_d = StIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seed_q      <= '0;
      h_q         <= '0;
      inside_q    <= 1'b0;
      word_q      <= '0;
      nbytes_q    <= '0;
      last_q      <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      hash_q      <= '0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      h_q         <= h_d;
      inside_q    <= inside_d;
      word_q      <= word_d;
      nbytes_q    <= nbytes_d;
      last_q      <= last_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      hash_q      <= hash_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

`ifndef SYNTH
  // The multiplier never runs while the input side is open.
  a_idle_mul_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !mul_rsp.busy)
    else $error("multiplier busy while sequencer idle");

  // A multiply is only started when the shared unit is free.
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier restarted while busy");

  // Leaving the result state always presents a result.
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && state_d == StIdle) |=> out_valid_q)
    else $error("result state left without loading the output");
`endif

endmodule
